FILE: rtl/rrt_pkg.sv
// shared types and constants of the tree extension planner
package rrt_pkg;

    localparam int CRD_W  = 16;
    localparam int LIM_W  = 7;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int D2_W   = 34;

    typedef logic [2:0][CRD_W-1:0] t_vec3;

    typedef struct packed {
        t_vec3            start;
        t_vec3            goal;
        logic [CRD_W-1:0] step;
        logic [5:0]       max_vert;
    } t_cfg;

    localparam logic [1:0] K_NODE = 2'd0;
    localparam logic [1:0] K_PATH = 2'd1;
    localparam logic [1:0] K_FAIL = 2'd2;

    localparam logic [2:0] REG_START_X = 3'd0;
    localparam logic [2:0] REG_START_Y = 3'd1;
    localparam logic [2:0] REG_START_Z = 3'd2;
    localparam logic [2:0] REG_GOAL_X  = 3'd3;
    localparam logic [2:0] REG_GOAL_Y  = 3'd4;
    localparam logic [2:0] REG_GOAL_Z  = 3'd5;
    localparam logic [2:0] REG_STEP    = 3'd6;
    localparam logic [2:0] REG_MAX_V   = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SQRT,
        S_MUL,
        S_DIV,
        S_STORE,
        S_GSQ,
        S_GCMP,
        S_OUT_NODE,
        S_OUT_FAIL,
        S_PATH_GOAL,
        S_PATH_RD,
        S_PATH_OUT
    } t_state;

endpackage

FILE: rtl/rrt_ram.sv
// generic single write port ram with registered read
module rrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/rrt_front.sv
// sample intake: masks coordinates and queues items for the engine
module rrt_front #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  rrt_pkg::t_vec3       i_smp,
    output logic                 o_vld,
    output rrt_pkg::t_vec3       o_smp,
    input  logic                 i_pop
);

    localparam int CWE = (COORD_WIDTH < rrt_pkg::CRD_W) ? COORD_WIDTH : rrt_pkg::CRD_W;
    localparam logic [rrt_pkg::CRD_W-1:0] MASK =
        rrt_pkg::CRD_W'((17'd1 << CWE) - 17'd1);

    rrt_pkg::t_vec3 r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    logic           pop;
    rrt_pkg::t_vec3 masked;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            masked[k] = i_smp[k] & MASK;
        end
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_vld   = (r_cnt != 2'd0);
    assign o_smp   = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= masked;
        end
    end

endmodule

FILE: rtl/rrt_back.sv
// extension engine: nearest scan, steering, append and path walk
module rrt_back #(
    parameter int MAX_NODES = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rrt_pkg::t_cfg              i_cfg,
    input  logic                       i_smp_vld,
    input  rrt_pkg::t_vec3             i_smp,
    output logic                       o_smp_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_kind,
    output rrt_pkg::t_vec3             o_point,
    output logic                       o_last
);

    localparam int IW  = $clog2(MAX_NODES);
    localparam int RW  = 3 * rrt_pkg::CRD_W + IW;
    localparam int D2W = rrt_pkg::D2_W;

    rrt_pkg::t_state r_state;
    rrt_pkg::t_state n_state;

    logic [IW-1:0]       raddr;
    logic [RW-1:0]       rdata;
    logic                we;

    rrt_pkg::t_vec3      r_root;
    rrt_pkg::t_vec3      r_s;
    logic [IW:0]         r_count;
    logic [IW:0]         r_iss;
    logic                r_p1_vld;
    logic [IW:0]         r_p1_idx;
    logic                r_p2_vld;
    logic [IW:0]         r_p2_idx;
    rrt_pkg::t_vec3      r_p2_c;
    logic [2:0][31:0]    r_sq;
    logic [D2W-1:0]      r_best_d;
    logic [IW-1:0]       r_best;
    rrt_pkg::t_vec3      r_best_c;
    logic [31:0]         r_step2;
    logic [D2W-1:0]      r_sv;
    logic [D2W-1:0]      r_sr;
    logic [D2W-1:0]      r_sbit;
    logic [1:0]          r_k;
    logic [16:0]         r_rem;
    logic [15:0]         r_lo;
    logic                r_gt;
    logic [3:0]          r_dcnt;
    rrt_pkg::t_vec3      r_nw;
    logic [IW:0]         r_idx;
    logic [IW-1:0]       r_cur;

    logic                r_o_vld;
    logic [1:0]          r_o_kind;
    rrt_pkg::t_vec3      r_o_pt;
    logic                r_o_last;

    rrt_pkg::t_vec3      c1;
    rrt_pkg::t_vec3      mx;
    rrt_pkg::t_vec3      my;
    logic [2:0][31:0]    sq;
    logic [D2W-1:0]      sum2;
    logic                scan_done;
    logic                free;
    logic                out_load;
    logic [D2W-1:0]      st;
    logic [15:0]         f;
    logic [15:0]         sk;
    logic [15:0]         delta;
    logic [31:0]         prod;
    logic [17:0]         rem2;
    logic                ge;
    logic [15:0]         q;
    logic [6:0]          mv7;
    logic [6:0]          lim;
    logic                fail;
    logic                goal_hit;
    rrt_pkg::t_vec3      mem_c;
    logic [IW-1:0]       mem_par;

    assign we = (r_state == rrt_pkg::S_STORE);

    rrt_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_NODES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata ({r_nw, r_best}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign mem_c   = rdata[RW-1:IW];
    assign mem_par = rdata[IW-1:0];
    assign raddr   = (r_state == rrt_pkg::S_SCAN) ? r_iss[IW-1:0] : r_cur;
    assign c1      = (r_p1_idx == '0) ? r_root : mem_c;
    assign mx      = (r_state == rrt_pkg::S_GSQ) ? r_nw : c1;
    assign my      = (r_state == rrt_pkg::S_GSQ) ? i_cfg.goal : r_s;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic [15:0] a;
            a     = (mx[k] > my[k]) ? (mx[k] - my[k]) : (my[k] - mx[k]);
            sq[k] = a * a;
        end
    end

    assign sum2      = D2W'(r_sq[0]) + D2W'(r_sq[1]) + D2W'(r_sq[2]);
    assign scan_done = (r_iss == r_count) && !r_p1_vld && !r_p2_vld;
    assign free      = !r_o_vld || i_out_ready;
    assign out_load  = free && ((r_state == rrt_pkg::S_OUT_NODE) ||
                                (r_state == rrt_pkg::S_OUT_FAIL) ||
                                (r_state == rrt_pkg::S_PATH_GOAL) ||
                                (r_state == rrt_pkg::S_PATH_OUT));
    assign st        = r_sr + r_sbit;

    assign f     = r_best_c[r_k];
    assign sk    = r_s[r_k];
    assign delta = (sk > f) ? (sk - f) : (f - sk);
    assign prod  = delta * i_cfg.step;
    assign rem2  = {r_rem, r_lo[15]};
    assign ge    = (rem2 >= {1'b0, r_sr[16:0]});
    assign q     = {r_lo[14:0], ge};

    assign mv7      = {1'b0, i_cfg.max_vert};
    assign lim      = (mv7 == '0) ? 7'd1 :
                      ((mv7 > 7'(MAX_NODES - 2)) ? 7'(MAX_NODES - 2) : mv7);
    assign fail     = (7'(r_idx) >= lim);
    assign goal_hit = (sum2 <= D2W'(r_step2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_smp_pop = 1'b0;
        case (r_state)
            rrt_pkg::S_IDLE: begin
                if (i_smp_vld) begin
                    o_smp_pop = 1'b1;
                    n_state   = rrt_pkg::S_SCAN;
                end
            end
            rrt_pkg::S_SCAN: begin
                if (scan_done) begin
                    n_state = (r_best_d > D2W'(r_step2)) ? rrt_pkg::S_SQRT : rrt_pkg::S_STORE;
                end
            end
            rrt_pkg::S_SQRT: begin
                if (r_sbit[0]) begin
                    n_state = rrt_pkg::S_MUL;
                end
            end
            rrt_pkg::S_MUL: n_state = rrt_pkg::S_DIV;
            rrt_pkg::S_DIV: begin
                if (r_dcnt == 4'd15) begin
                    n_state = (r_k == 2'd2) ? rrt_pkg::S_STORE : rrt_pkg::S_MUL;
                end
            end
            rrt_pkg::S_STORE: n_state = rrt_pkg::S_GSQ;
            rrt_pkg::S_GSQ:   n_state = rrt_pkg::S_GCMP;
            rrt_pkg::S_GCMP: begin
                n_state = goal_hit ? rrt_pkg::S_PATH_GOAL : rrt_pkg::S_OUT_NODE;
            end
            rrt_pkg::S_OUT_NODE: begin
                if (free) begin
                    n_state = fail ? rrt_pkg::S_OUT_FAIL : rrt_pkg::S_IDLE;
                end
            end
            rrt_pkg::S_OUT_FAIL: begin
                if (free) begin
                    n_state = rrt_pkg::S_IDLE;
                end
            end
            rrt_pkg::S_PATH_GOAL: begin
                if (free) begin
                    n_state = rrt_pkg::S_PATH_RD;
                end
            end
            rrt_pkg::S_PATH_RD: n_state = rrt_pkg::S_PATH_OUT;
            rrt_pkg::S_PATH_OUT: begin
                if (free) begin
                    n_state = (r_cur == '0) ? rrt_pkg::S_IDLE : rrt_pkg::S_PATH_RD;
                end
            end
            default: n_state = rrt_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= (IW+1)'(1);
            r_root   <= '0;
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            r_p2_vld <= r_p1_vld;
            r_p1_vld <= (r_state == rrt_pkg::S_SCAN) && (r_iss != r_count);
            if (out_load) begin
                r_o_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_o_vld <= 1'b0;
            end
            case (r_state)
                rrt_pkg::S_STORE: r_count <= r_count + (IW+1)'(1);
                default: ;
            endcase
            if (free && ((r_state == rrt_pkg::S_OUT_FAIL) ||
                         ((r_state == rrt_pkg::S_PATH_OUT) && (r_cur == '0)))) begin
                r_count <= (IW+1)'(1);
                r_root  <= i_cfg.start;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_step2  <= i_cfg.step * i_cfg.step;
        r_p1_idx <= r_iss;
        r_p2_idx <= r_p1_idx;
        r_p2_c   <= c1;
        if (r_p1_vld || (r_state == rrt_pkg::S_GSQ)) begin
            r_sq <= sq;
        end
        case (r_state)
            rrt_pkg::S_IDLE: begin
                r_s      <= i_smp;
                r_iss    <= '0;
                r_best_d <= '1;
            end
            rrt_pkg::S_SCAN: begin
                if (r_iss != r_count) begin
                    r_iss <= r_iss + (IW+1)'(1);
                end
                if (r_p2_vld && (sum2 < r_best_d)) begin
                    r_best_d <= sum2;
                    r_best   <= r_p2_idx[IW-1:0];
                    r_best_c <= r_p2_c;
                end
                r_sv   <= r_best_d;
                r_sr   <= '0;
                r_sbit <= D2W'(1) << 32;
                r_k    <= 2'd0;
                r_nw   <= r_s;
            end
            rrt_pkg::S_SQRT: begin
                if (r_sv >= st) begin
                    r_sv <= r_sv - st;
                    r_sr <= (r_sr >> 1) + r_sbit;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sbit <= r_sbit >> 2;
            end
            rrt_pkg::S_MUL: begin
                r_rem  <= {1'b0, prod[31:16]};
                r_lo   <= prod[15:0];
                r_gt   <= (sk > f);
                r_dcnt <= '0;
            end
            rrt_pkg::S_DIV: begin
                r_rem  <= ge ? 17'(rem2 - {1'b0, r_sr[16:0]}) : rem2[16:0];
                r_lo   <= q;
                r_dcnt <= r_dcnt + 4'd1;
                if (r_dcnt == 4'd15) begin
                    r_nw[r_k] <= r_gt ? (f + q) : (f - q);
                    r_k       <= r_k + 2'd1;
                end
            end
            rrt_pkg::S_STORE: r_idx <= r_count;
            rrt_pkg::S_OUT_NODE: begin
                if (free) begin
                    r_o_kind <= rrt_pkg::K_NODE;
                    r_o_pt   <= r_nw;
                    r_o_last <= !fail;
                end
            end
            rrt_pkg::S_OUT_FAIL: begin
                if (free) begin
                    r_o_kind <= rrt_pkg::K_FAIL;
                    r_o_pt   <= '0;
                    r_o_last <= 1'b1;
                end
            end
            rrt_pkg::S_PATH_GOAL: begin
                if (free) begin
                    r_o_kind <= rrt_pkg::K_PATH;
                    r_o_pt   <= i_cfg.goal;
                    r_o_last <= 1'b0;
                    r_cur    <= r_idx[IW-1:0];
                end
            end
            rrt_pkg::S_PATH_OUT: begin
                if (free) begin
                    r_o_kind <= rrt_pkg::K_PATH;
                    r_o_pt   <= (r_cur == '0) ? r_root : mem_c;
                    r_o_last <= (r_cur == '0);
                    r_cur    <= mem_par;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_o_vld;
    assign o_kind      = r_o_kind;
    assign o_point     = r_o_pt;
    assign o_last      = r_o_last;

endmodule

FILE: rtl/rrt_tree_extend_planner.sv
// top level of the tree extension planner: config registers, intake and engine
// Usage:
//   Each input item on i_in_valid/o_in_ready is one sample point (Q8.8).
//   For each item the engine finds the nearest tree node (lowest index on
//   ties), steers toward the sample by at most step_length, appends the node
//   and returns result items on o_out_valid/i_out_ready: one node item, or a
//   node item and a failure item when the sample budget runs out, or, when
//   the goal is reached, the path from goal back to root with o_last on root.
//   Per item the engine runs a nearest scan over the tree nodes (one node read
//   per cycle from the node ram), then, when steering, a square root and
//   three divides, then append and goal test; a path reads the node ram once
//   for each point after the goal.
//   A two-entry queue in front keeps accepting samples while the engine works
//   until full. If the receiver stalls, the engine holds its result and waits.
//   Reset loads control registers to defaults, the tree to root only. Users
//   write configuration over the apb port while the block is idle, unchecked.
module rrt_tree_extend_planner #(
    parameter int MAX_NODES   = 64,
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rrt_pkg::ADDR_W-1:0]    paddr,
    input  logic [rrt_pkg::DATA_W-1:0]    pwdata,
    output logic [rrt_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [15:0]                   i_sample_x,
    input  logic [15:0]                   i_sample_y,
    input  logic [15:0]                   i_sample_z,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_kind,
    output logic [15:0]                   o_point_x,
    output logic [15:0]                   o_point_y,
    output logic [15:0]                   o_point_z,
    output logic                          o_last
);

    localparam int CWE = (COORD_WIDTH < rrt_pkg::CRD_W) ? COORD_WIDTH : rrt_pkg::CRD_W;
    localparam logic [rrt_pkg::CRD_W-1:0] MASK =
        rrt_pkg::CRD_W'((17'd1 << CWE) - 17'd1);

    rrt_pkg::t_vec3   r_start;
    rrt_pkg::t_vec3   r_goal;
    logic [15:0]      r_step;
    logic [5:0]       r_max_v;
    rrt_pkg::t_cfg    cfg;
    rrt_pkg::t_vec3   smp_in;
    rrt_pkg::t_vec3   smp;
    rrt_pkg::t_vec3   pt;
    logic             smp_vld;
    logic             smp_pop;
    logic             wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_goal  <= {16'd0, 16'd25600, 16'd25600};
            r_step  <= 16'd768;
            r_max_v <= 6'd62;
        end else if (wr) begin
            case (paddr[4:2])
                rrt_pkg::REG_START_X: r_start[0] <= pwdata[15:0];
                rrt_pkg::REG_START_Y: r_start[1] <= pwdata[15:0];
                rrt_pkg::REG_START_Z: r_start[2] <= pwdata[15:0];
                rrt_pkg::REG_GOAL_X:  r_goal[0]  <= pwdata[15:0];
                rrt_pkg::REG_GOAL_Y:  r_goal[1]  <= pwdata[15:0];
                rrt_pkg::REG_GOAL_Z:  r_goal[2]  <= pwdata[15:0];
                rrt_pkg::REG_STEP:    r_step     <= pwdata[15:0];
                rrt_pkg::REG_MAX_V:   r_max_v    <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            rrt_pkg::REG_START_X: prdata = {16'd0, r_start[0]};
            rrt_pkg::REG_START_Y: prdata = {16'd0, r_start[1]};
            rrt_pkg::REG_START_Z: prdata = {16'd0, r_start[2]};
            rrt_pkg::REG_GOAL_X:  prdata = {16'd0, r_goal[0]};
            rrt_pkg::REG_GOAL_Y:  prdata = {16'd0, r_goal[1]};
            rrt_pkg::REG_GOAL_Z:  prdata = {16'd0, r_goal[2]};
            rrt_pkg::REG_STEP:    prdata = {16'd0, r_step};
            rrt_pkg::REG_MAX_V:   prdata = {26'd0, r_max_v};
            default:              prdata = '0;
        endcase
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cfg.start[k] = r_start[k] & MASK;
            cfg.goal[k]  = r_goal[k] & MASK;
        end
        cfg.step     = r_step;
        cfg.max_vert = r_max_v;
    end

    assign smp_in = {i_sample_z, i_sample_y, i_sample_x};

    rrt_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_smp   (smp_in),
        .o_vld   (smp_vld),
        .o_smp   (smp),
        .i_pop   (smp_pop)
    );

    rrt_back #(
        .MAX_NODES (MAX_NODES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_smp_vld   (smp_vld),
        .i_smp       (smp),
        .o_smp_pop   (smp_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_kind      (o_kind),
        .o_point     (pt),
        .o_last      (o_last)
    );

    assign o_point_x = pt[0];
    assign o_point_y = pt[1];
    assign o_point_z = pt[2];

`ifndef SYNTHESIS
    a_kind_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_kind == rrt_pkg::K_NODE || o_kind == rrt_pkg::K_PATH ||
                         o_kind == rrt_pkg::K_FAIL))
        else $error("unknown result kind");
    a_fail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == rrt_pkg::K_FAIL) |-> (o_last && pt == '0))
        else $error("failure item must be last and carry no point");
    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last) |=> !(o_out_valid && o_last &&
                                                      $stable(pt) && $stable(o_kind) &&
                                                      o_kind == rrt_pkg::K_FAIL))
        else $error("failure item repeated");
`endif

endmodule
